// ----- sv/bsfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Band scalefactor search package
// Shared constants, tables, state types and the probe request/response
// structs of the band scalefactor search block.
// ----------------------------------------------------------------------------
package bsfs_pkg;

  // Default sizes.
  localparam int MAX_BAND_DEF  = 256;
  localparam int MAX_INDEX_DEF = 8206;

  // Search constants.
  localparam int COARSE_STEPS   = 7;
  localparam int START_QUARTERS = -82;
  localparam int START_STEP     = 128;

  // The cube root of i * 2^42 always fits in this many bits.
  localparam int CBRT_BITS = 19;

  // Width of the Q1.16 scaled power table entries.
  localparam int POW_W = 17;

  // Probe request from the search control to the probe datapath.
  typedef struct packed {
    logic              start;
    logic signed [8:0] q;
  } probe_req_t;

  // Probe response: done pulses for one cycle at the end of a probe.
  typedef struct packed {
    logic        done;
    logic        ok;
    logic [63:0] sum;
  } probe_resp_t;

  // Search control states.
  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_LIM_LO,
    S_LIM_HI,
    S_LIM_SUM,
    S_COARSE_GO,
    S_COARSE_WAIT,
    S_REF3_GO,
    S_REF3_WAIT,
    S_REF1_GO,
    S_REF1_WAIT
  } search_state_t;

  // Probe datapath states, one pass per coefficient.
  typedef enum logic [3:0] {
    P_IDLE,
    P_RD,
    P_MUL,
    P_SH,
    P_L0,
    P_L1,
    P_L2,
    P_SQ,
    P_ACC
  } probe_state_t;

  // Power table fill states.
  typedef enum logic [1:0] {
    F_SQ,
    F_CUBE,
    F_WRITE,
    F_DONE
  } fill_state_t;

  // 2^(k/16) in Q1.16, rounded.
  function automatic logic [POW_W-1:0] pow16(input logic [3:0] k);
    logic [POW_W-1:0] v;
    unique case (k)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd68438;
      4'd2:  v = 17'd71468;
      4'd3:  v = 17'd74632;
      4'd4:  v = 17'd77936;
      4'd5:  v = 17'd81386;
      4'd6:  v = 17'd84990;
      4'd7:  v = 17'd88752;
      4'd8:  v = 17'd92682;
      4'd9:  v = 17'd96785;
      4'd10: v = 17'd101070;
      4'd11: v = 17'd105545;
      4'd12: v = 17'd110218;
      4'd13: v = 17'd115098;
      4'd14: v = 17'd120194;
      4'd15: v = 17'd125515;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/bsfs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bsfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bsfs_fill.sv -----
// ----------------------------------------------------------------------------
// Power table fill
// After reset, writes i * floor(cbrt(i * 2^42)) for every table index,
// finding each cube root one bit at a time with a square and a cube step.
// ----------------------------------------------------------------------------
module bsfs_fill #(
  parameter int MAX_INDEX = bsfs_pkg::MAX_INDEX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  output logic                               ready,
  output logic                               we,
  output logic [$clog2(MAX_INDEX+1)-1:0]     waddr,
  output logic [31:0]                        wdata
);
  import bsfs_pkg::*;

  localparam int IXW = $clog2(MAX_INDEX + 1);
  localparam logic [IXW-1:0] LAST_IDX = IXW'(MAX_INDEX);
  localparam logic [4:0] TOP_BIT = 5'(CBRT_BITS - 1);

  fill_state_t state, state_next;

  logic [IXW-1:0]         idx;
  logic [CBRT_BITS-1:0]   root;
  logic [4:0]             bitn;
  logic [2*CBRT_BITS-1:0] sq;
  logic [CBRT_BITS-1:0]   cand;
  logic [3*CBRT_BITS-1:0] cube;
  logic [IXW+CBRT_BITS-1:0] entry;
  logic                   fits;

  // Trial root, its cube and the finished entry.
  always_comb begin
    cand  = root | (CBRT_BITS'(1) << bitn);
    cube  = sq * cand;
    fits  = {7'd0, cube} <= 64'({idx, 42'd0});
    entry = idx * root;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_SQ;
    end else begin
      state <= state_next;
    end
  end

  // Next state and write port.
  always_comb begin
    state_next = state;
    we         = 1'b0;
    ready      = 1'b0;
    unique case (state)
      F_SQ: begin
        state_next = F_CUBE;
      end
      F_CUBE: begin
        state_next = (bitn == 5'd0) ? F_WRITE : F_SQ;
      end
      F_WRITE: begin
        we         = 1'b1;
        state_next = (idx == LAST_IDX) ? F_DONE : F_SQ;
      end
      F_DONE: begin
        ready = 1'b1;
      end
      default: begin
        state_next = F_SQ;
      end
    endcase
  end

  assign waddr = idx;
  assign wdata = 32'(entry);

  // Index, root and bit counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      root <= '0;
      bitn <= TOP_BIT;
    end else begin
      unique case (state)
        F_SQ: begin
          sq <= cand * cand;
        end
        F_CUBE: begin
          if (fits) begin
            root <= cand;
          end
          if (bitn != 5'd0) begin
            bitn <= bitn - 5'd1;
          end
        end
        F_WRITE: begin
          if (idx != LAST_IDX) begin
            idx  <= idx + IXW'(1);
            root <= '0;
            bitn <= TOP_BIT;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/bsfs_probe.sv -----
// ----------------------------------------------------------------------------
// Band probe datapath
// Quantizes every stored coefficient at one scalefactor, picks the nearer
// reconstruction level and sums the saturated squared error.
// ----------------------------------------------------------------------------
module bsfs_probe #(
  parameter int MAX_BAND  = bsfs_pkg::MAX_BAND_DEF,
  parameter int MAX_INDEX = bsfs_pkg::MAX_INDEX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bsfs_pkg::probe_req_t               req,
  output bsfs_pkg::probe_resp_t              resp,
  input  logic [$clog2(MAX_BAND+1)-1:0]      count,
  output logic [$clog2(MAX_BAND)-1:0]        band_raddr,
  input  logic [63:0]                        band_rdata,
  output logic [$clog2(MAX_INDEX+1)-1:0]     rom_raddr,
  input  logic [31:0]                        rom_rdata
);
  import bsfs_pkg::*;

  localparam int CW  = $clog2(MAX_BAND + 1);
  localparam int AW  = $clog2(MAX_BAND);
  localparam int IXW = $clog2(MAX_INDEX + 1);
  localparam logic [CW-1:0]  J_STEP  = CW'(1);
  localparam logic [IXW-1:0] IX_LAST = IXW'(MAX_INDEX);

  // x * 2^(-s), saturating when a left shift would leave 64 bits.
  function automatic logic [63:0] shift_scale(input logic [63:0] x,
                                              input logic signed [7:0] s);
    logic [7:0]  k;
    logic [63:0] v;
    k = 8'(-s);
    if (s >= 8'sd64) begin
      v = '0;
    end else if (s >= 8'sd0) begin
      v = x >> s[5:0];
    end else if (k >= 8'd64) begin
      v = (x != '0) ? '1 : '0;
    end else if ((x >> (7'd64 - k[6:0])) != '0) begin
      v = '1;
    end else begin
      v = x << k[5:0];
    end
    return v;
  endfunction

  function automatic logic [63:0] abs_diff(input logic [63:0] a,
                                           input logic [63:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  probe_state_t state, state_next;

  // Probe constants derived from the exponent.
  logic signed [10:0] qx;
  logic signed [10:0] e;
  logic signed [7:0]  sh_ix_c;
  logic signed [7:0]  sh_lv_c;

  logic [POW_W-1:0]  p16b;
  logic [POW_W-1:0]  p4r;
  logic signed [7:0] sh_ix;
  logic signed [7:0] sh_lv;

  logic [CW-1:0]    j;
  logic [31:0]      mag;
  logic [48:0]      pw;
  logic [IXW-1:0]   ix;
  logic [48:0]      prod;
  logic [63:0]      dbest;
  logic [63:0]      term;
  logic [63:0]      sum;
  logic             done_r;
  logic             ok_r;

  logic [63:0]      ixw;
  logic             ix_over;
  logic [63:0]      d_cur;
  logic [63:0]      sq_full;
  logic [64:0]      sum_wide;
  logic             j_last;

  always_comb begin
    qx      = {{2{req.q[8]}}, req.q};
    e       = 11'sd0 - (qx + qx + qx);
    sh_ix_c = 8'sd32 - {e[10], e[10:4]};
    sh_lv_c = 8'sd14 - {req.q[8], req.q[8:2]};
  end

  // Per-coefficient arithmetic.
  always_comb begin
    ixw      = shift_scale({15'd0, pw}, sh_ix);
    ix_over  = ixw > 64'(MAX_INDEX);
    d_cur    = abs_diff({32'd0, mag}, shift_scale({15'd0, prod}, sh_lv));
    sq_full  = dbest[31:0] * dbest[31:0];
    sum_wide = {1'b0, sum} + {1'b0, term};
    j_last   = (j + J_STEP) == count;
  end

  assign band_raddr = j[AW-1:0];

  // Table address: the base level, then its upper neighbor.
  always_comb begin
    if (state == P_SH) begin
      rom_raddr = ixw[IXW-1:0];
    end else if (ix != IX_LAST) begin
      rom_raddr = ix + IXW'(1);
    end else begin
      rom_raddr = ix;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      P_IDLE:  state_next = req.start ? P_RD : P_IDLE;
      P_RD:    state_next = P_MUL;
      P_MUL:   state_next = P_SH;
      P_SH:    state_next = ix_over ? P_IDLE : P_L0;
      P_L0:    state_next = P_L1;
      P_L1:    state_next = P_L2;
      P_L2:    state_next = P_SQ;
      P_SQ:    state_next = P_ACC;
      P_ACC:   state_next = j_last ? P_IDLE : P_RD;
      default: state_next = P_IDLE;
    endcase
  end

  // Response flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      done_r <= 1'b0;
      ok_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (state == P_SH && ix_over) begin
        done_r <= 1'b1;
        ok_r   <= 1'b0;
      end else if (state == P_ACC && j_last) begin
        done_r <= 1'b1;
        ok_r   <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      P_IDLE: begin
        p16b  <= pow16(e[3:0]);
        p4r   <= pow16({req.q[1:0], 2'b00});
        sh_ix <= sh_ix_c;
        sh_lv <= sh_lv_c;
        j     <= '0;
        sum   <= '0;
      end
      P_MUL: begin
        pw  <= band_rdata[63:32] * p16b;
        mag <= band_rdata[31:0];
      end
      P_SH: begin
        ix <= ixw[IXW-1:0];
      end
      P_L0: begin
        prod <= rom_rdata * p4r;
      end
      P_L1: begin
        dbest <= d_cur;
        prod  <= rom_rdata * p4r;
      end
      P_L2: begin
        if (ix != IX_LAST && d_cur < dbest) begin
          dbest <= d_cur;
        end
      end
      P_SQ: begin
        term <= (dbest[63:32] != '0) ? '1 : sq_full;
      end
      P_ACC: begin
        sum <= sum_wide[64] ? '1 : sum_wide[63:0];
        j   <= j + J_STEP;
      end
      default: begin
      end
    endcase
  end

  assign resp.done = done_r;
  assign resp.ok   = ok_r;
  assign resp.sum  = sum;

endmodule

// ----- sv/band_scalefactor_search.sv -----
// ----------------------------------------------------------------------------
// Band scalefactor search
// Loads one band of coefficients and searches its scalefactor exponent.
// ----------------------------------------------------------------------------
// After reset the block fills its 4/3 power table; busy is high until then.
// A coefficient is taken whenever start is high and busy is low. The transfer
// with last set closes the band and starts the search: a limit setup in
// S_LIM_LO, S_LIM_HI and S_LIM_SUM, then seven coarse probes and at most two
// refinement probes, each probe passing every stored coefficient through the
// single probe datapath and its two reads of the power table memory.
// The result is shown for one cycle with done high and must be taken then;
// busy falls in the same cycle.
module band_scalefactor_search #(
  parameter int MAX_BAND  = bsfs_pkg::MAX_BAND_DEF,
  parameter int MAX_INDEX = bsfs_pkg::MAX_INDEX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       coef_mag,
  input  logic [31:0]       coef_pow34,
  input  logic [63:0]       noise_limit,
  input  logic              last,
  output logic              done,
  output logic signed [8:0] scale_quarters,
  output logic              found
);
  import bsfs_pkg::*;

  localparam int CW  = $clog2(MAX_BAND + 1);
  localparam int AW  = $clog2(MAX_BAND);
  localparam int IXW = $clog2(MAX_INDEX + 1);
  localparam logic [CW-1:0] BAND_FULL = CW'(MAX_BAND);
  localparam logic [2:0]    LAST_STEP = 3'(COARSE_STEPS - 1);

  search_state_t state, state_next;

  logic [CW-1:0]     count;
  logic [63:0]       limit;
  logic [31+CW:0]    lim_lo;
  logic [31+CW:0]    lim_hi;
  logic [63:0]       lim_n;
  logic              lim_ovf;
  logic [64+CW:0]    lim_full;
  logic signed [8:0] probe_q;
  logic signed [8:0] best_q;
  logic              best_valid;
  logic [2:0]        iter;
  logic [6:0]        step;
  logic              exceeds;
  logic              accept_ref;
  logic              take_in;

  probe_req_t  req;
  probe_resp_t resp;

  logic           fill_ready;
  logic           rom_we;
  logic [IXW-1:0] rom_waddr;
  logic [31:0]    rom_wdata;
  logic [IXW-1:0] rom_raddr;
  logic [31:0]    rom_rdata;
  logic [AW-1:0]  band_raddr;
  logic [63:0]    band_rdata;
  logic           band_we;

  // Power table fill after reset.
  bsfs_fill #(
    .MAX_INDEX(MAX_INDEX)
  ) u_fill (
    .clk  (clk),
    .rst  (rst),
    .ready(fill_ready),
    .we   (rom_we),
    .waddr(rom_waddr),
    .wdata(rom_wdata)
  );

  // Power table memory.
  bsfs_ram #(
    .WIDTH(32),
    .DEPTH(MAX_INDEX + 1)
  ) u_rom (
    .clk  (clk),
    .we   (rom_we),
    .waddr(rom_waddr),
    .wdata(rom_wdata),
    .raddr(rom_raddr),
    .rdata(rom_rdata)
  );

  // Band store: 3/4 power in the upper word, magnitude in the lower.
  bsfs_ram #(
    .WIDTH(64),
    .DEPTH(MAX_BAND)
  ) u_band (
    .clk  (clk),
    .we   (band_we),
    .waddr(count[AW-1:0]),
    .wdata({coef_pow34, coef_mag}),
    .raddr(band_raddr),
    .rdata(band_rdata)
  );

  // Probe datapath.
  bsfs_probe #(
    .MAX_BAND (MAX_BAND),
    .MAX_INDEX(MAX_INDEX)
  ) u_probe (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .resp      (resp),
    .count     (count),
    .band_raddr(band_raddr),
    .band_rdata(band_rdata),
    .rom_raddr (rom_raddr),
    .rom_rdata (rom_rdata)
  );

  // Transfer and store write.
  assign busy    = (state != S_IDLE);
  assign take_in = start && !busy;
  assign band_we = take_in && (count < BAND_FULL);

  // Coarse step, limit test and refinement acceptance.
  always_comb begin
    step       = 7'(8'(START_STEP) >> (iter + 3'd1));
    lim_full   = {1'b0, lim_hi, 32'd0} + {33'd0, lim_lo};
    exceeds    = !lim_ovf && (resp.sum > lim_n);
    accept_ref = resp.ok && (resp.sum != '0) && !exceeds;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      state <= state_next;
    end
  end

  // Next state and probe requests.
  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.q      = probe_q;
    unique case (state)
      S_FILL: begin
        state_next = fill_ready ? S_IDLE : S_FILL;
      end
      S_IDLE: begin
        state_next = (take_in && last) ? S_LIM_LO : S_IDLE;
      end
      S_LIM_LO: begin
        state_next = S_LIM_HI;
      end
      S_LIM_HI: begin
        state_next = S_LIM_SUM;
      end
      S_LIM_SUM: begin
        state_next = S_COARSE_GO;
      end
      S_COARSE_GO: begin
        req.start  = 1'b1;
        state_next = S_COARSE_WAIT;
      end
      S_COARSE_WAIT: begin
        if (resp.done) begin
          if (iter != LAST_STEP) begin
            state_next = S_COARSE_GO;
          end else if (best_valid || resp.ok) begin
            state_next = S_REF3_GO;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_REF3_GO: begin
        req.start  = 1'b1;
        req.q      = best_q + 9'sd3;
        state_next = S_REF3_WAIT;
      end
      S_REF3_WAIT: begin
        if (resp.done) begin
          state_next = accept_ref ? S_IDLE : S_REF1_GO;
        end
      end
      S_REF1_GO: begin
        req.start  = 1'b1;
        req.q      = best_q + 9'sd1;
        state_next = S_REF1_WAIT;
      end
      S_REF1_WAIT: begin
        if (resp.done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers: band count, search state and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      probe_q    <= 9'(START_QUARTERS);
      best_q     <= '0;
      best_valid <= 1'b0;
      iter       <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (band_we) begin
            count <= count + CW'(1);
          end
        end
        S_LIM_LO: begin
          probe_q    <= 9'(START_QUARTERS);
          best_q     <= '0;
          best_valid <= 1'b0;
          iter       <= '0;
        end
        S_COARSE_WAIT: begin
          if (resp.done) begin
            iter <= iter + 3'd1;
            if (!resp.ok) begin
              probe_q <= probe_q + $signed({2'b00, step});
            end else begin
              best_valid <= 1'b1;
              if (!best_valid) begin
                best_q <= probe_q;
              end
              if (exceeds) begin
                probe_q <= probe_q - $signed({2'b00, step});
              end else begin
                best_q  <= probe_q;
                probe_q <= probe_q + $signed({2'b00, step});
              end
            end
            if (iter == LAST_STEP && !(best_valid || resp.ok)) begin
              done           <= 1'b1;
              scale_quarters <= '0;
              found          <= 1'b0;
              count          <= '0;
            end
          end
        end
        S_REF3_WAIT: begin
          if (resp.done && accept_ref) begin
            done           <= 1'b1;
            scale_quarters <= best_q + 9'sd3;
            found          <= 1'b1;
            count          <= '0;
          end
        end
        S_REF1_WAIT: begin
          if (resp.done) begin
            done           <= 1'b1;
            scale_quarters <= accept_ref ? (best_q + 9'sd1) : best_q;
            found          <= 1'b1;
            count          <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Noise limit times band count, in two half-width products.
  always_ff @(posedge clk) begin
    if (take_in && last) begin
      limit <= noise_limit;
    end
    unique case (state)
      S_LIM_LO: begin
        lim_lo <= limit[31:0] * count;
      end
      S_LIM_HI: begin
        lim_hi <= limit[63:32] * count;
      end
      S_LIM_SUM: begin
        lim_n   <= lim_full[63:0];
        lim_ovf <= lim_full[64+CW:64] != '0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- tb/band_scalefactor_search_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Band scalefactor search testbench
// Sends bands of coefficients through the start/busy command interface,
// predicts each band's scalefactor search in the testbench and checks every
// done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module band_scalefactor_search_tb;
  import bsfs_pkg::*;

  localparam int  MAX_BAND    = MAX_BAND_DEF;
  localparam int  MAX_INDEX   = MAX_INDEX_DEF;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  DRAIN_WAIT  = 200;
  localparam bit [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [8:0] scale;
    logic              found;
  } scale_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [31:0]       coef_mag = '0;
  logic [31:0]       coef_pow34 = '0;
  logic [63:0]       noise_limit = '0;
  logic              last = 1'b0;
  logic              done;
  logic signed [8:0] scale_quarters;
  logic              found;

  // Predictor state: the power table and the band being loaded.
  bit [31:0] pow43_table [MAX_INDEX + 2];
  bit [31:0] band_mag [MAX_BAND];
  bit [31:0] band_pow [MAX_BAND];
  int        band_len;
  bit [63:0] probe_sum;

  scale_result_t scale_expect_q [$];
  int            error_count;
  int            cycle_count;

  // Sender burst control.
  bit gaps_on;
  int burst_left;

  band_scalefactor_search DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_mag(coef_mag), .coef_pow34(coef_pow34), .noise_limit(noise_limit),
    .last(last), .done(done), .scale_quarters(scale_quarters), .found(found)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Scaling by 2^-s with a saturating left shift for negative s.
  function automatic bit [63:0] shift_scaled(bit [63:0] x, int s);
    int k;
    if (s >= 64) return 64'd0;
    if (s >= 0) return x >> s;
    k = -s;
    if (k >= 64) return (x != 0) ? ALL_ONES : 64'd0;
    if (x > (ALL_ONES >> k)) return ALL_ONES;
    return x << k;
  endfunction

  function automatic int div_floor(int n, int d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic bit [63:0] pow2_frac(int k);
    return 64'(pow16(4'(k & 15)));
  endfunction

  function automatic bit [63:0] recon_level(int ix, int q);
    int c;
    int r;
    c = div_floor(q, 4);
    r = q - 4 * c;
    return shift_scaled(64'(pow43_table[ix]) * pow2_frac(r * 4), 14 - c);
  endfunction

  function automatic bit [63:0] abs_gap(bit [63:0] a, bit [63:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Quantizes the band at exponent q; returns 0 on index overflow.
  function automatic bit probe_band(int q);
    int        e;
    int        a;
    int        b;
    int        ix;
    bit [63:0] ixw;
    bit [63:0] d;
    bit [63:0] d2;
    bit [63:0] term;
    e = -3 * q;
    a = div_floor(e, 16);
    b = e - 16 * a;
    probe_sum = 0;
    for (int j = 0; j < band_len; j++) begin
      ixw = shift_scaled(64'(band_pow[j]) * pow2_frac(b), 32 - a);
      if (ixw > 64'(MAX_INDEX)) return 1'b0;
      ix = int'(ixw);
      d = abs_gap(64'(band_mag[j]), recon_level(ix, q));
      if (ix < MAX_INDEX) begin
        d2 = abs_gap(64'(band_mag[j]), recon_level(ix + 1, q));
        if (d2 < d) d = d2;
      end
      term = (d > 64'hFFFF_FFFF) ? ALL_ONES : d * d;
      probe_sum = (probe_sum > ALL_ONES - term) ? ALL_ONES : probe_sum + term;
    end
    return 1'b1;
  endfunction

  // Average noise test done as sum > limit * count.
  function automatic bit over_limit(bit [63:0] sum, bit [63:0] lim);
    bit [63:0] n;
    n = 64'(band_len);
    if (n == 0) return 1'b0;
    if (lim > ALL_ONES / n) return 1'b0;
    return sum > lim * n;
  endfunction

  // Coarse halving search followed by the +3 / +1 refinement.
  function automatic scale_result_t search_scalefactor(bit [63:0] lim);
    scale_result_t res;
    int            probe_q;
    int            step;
    int            best;
    bit            best_ok;
    int            pick;
    int            cand;
    probe_q = START_QUARTERS;
    step    = START_STEP;
    best    = 0;
    best_ok = 1'b0;
    for (int i = 0; i < COARSE_STEPS; i++) begin
      step = step / 2;
      if (!probe_band(probe_q)) begin
        probe_q += step;
      end else begin
        if (!best_ok) begin
          best    = probe_q;
          best_ok = 1'b1;
        end
        if (over_limit(probe_sum, lim)) begin
          probe_q -= step;
        end else begin
          best    = probe_q;
          probe_q += step;
        end
      end
    end
    pick = 0;
    if (best_ok) begin
      pick = best;
      cand = best + 3;
      while (cand > best) begin
        if (cand == best + 2 * step) cand--;
        if (cand <= best) break;
        if (probe_band(cand) && probe_sum > 0 && !over_limit(probe_sum, lim)) begin
          pick = cand;
          break;
        end
        cand--;
      end
    end
    res.scale = 9'(pick);
    res.found = best_ok;
    return res;
  endfunction

  function automatic bit [63:0] cube_root_floor(bit [63:0] v);
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] mid;
    lo = 0;
    hi = 64'd1 << 19;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // Sends one coefficient, honoring the burst pattern, and predicts on transfer.
  task automatic send_coef(bit [31:0] mag, bit [31:0] pw, bit [63:0] lim, bit lst);
    bit b;
    if (gaps_on && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    start       <= 1'b1;
    coef_mag    <= mag;
    coef_pow34  <= pw;
    noise_limit <= lim;
    last        <= lst;
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
    if (burst_left > 0) burst_left--;
    if (band_len < MAX_BAND) begin
      band_mag[band_len] = mag;
      band_pow[band_len] = pw;
      band_len++;
    end
    if (lst) begin
      scale_expect_q.push_back(search_scalefactor(lim));
      band_len = 0;
    end
  endtask

  // Magnitude with a matching 3/4 power, spread over many octaves.
  task automatic send_natural(bit [63:0] lim, bit lst);
    bit [31:0] m;
    real       pr;
    m  = $urandom >> $urandom_range(0, 31);
    pr = ((real'(m) / 65536.0) ** 0.75) * 65536.0;
    if (pr > 4294967295.0) pr = 4294967295.0;
    send_coef(m, 32'(longint'(pr)), lim, lst);
  endtask

  function automatic bit [63:0] random_limit();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return ALL_ONES;
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  task automatic send_band(int len, bit noisy);
    bit [63:0] lim;
    for (int i = 0; i < len; i++) begin
      lim = random_limit();
      if (noisy && $urandom_range(0, 3) == 0) send_coef($urandom, $urandom, lim, i == len - 1);
      else send_natural(lim, i == len - 1);
    end
  endtask

  // Extremes of the fields, limit corner cases and zero-error bands.
  task automatic test_directed();
    send_coef(32'd0, 32'd0, 64'd0, 1'b1);
    send_coef(32'd0, 32'd0, ALL_ONES, 1'b1);
    send_coef(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 1'b1);
    send_coef(32'hFFFF_FFFF, 32'hFFFF_FFFF, ALL_ONES, 1'b1);
    send_coef(32'hFFFF_FFFF, 32'd0, 64'd1, 1'b0);
    send_coef(32'd0, 32'hFFFF_FFFF, ALL_ONES, 1'b1);
    send_coef(32'h0001_0000, 32'h0001_0000, 64'd0, 1'b1);
    send_coef(32'h0010_0000, 32'h0008_0000, 64'h0000_0001_0000_0000, 1'b1);
    // Limit times count passes 64 bits, so the test is never exceeded.
    send_coef(32'h1234_5678, 32'h0ABC_DEF0, 64'd0, 1'b0);
    send_coef(32'h8765_4321, 32'h0123_4567, 64'h8000_0000_0000_0000, 1'b1);
    for (int i = 0; i < 4; i++) send_coef(32'h5555_5555, 32'hAAAA_AAAA, 64'h5555, i == 3);
    for (int i = 0; i < 4; i++) send_coef(32'hAAAA_AAAA, 32'h5555_5555, 64'hAAAA, i == 3);
    for (int i = 0; i < 5; i++) send_natural(64'h0000_0000_0100_0000, i == 4);
  endtask

  // A band longer than the store: the excess coefficients are dropped.
  task automatic test_long_band();
    send_band(MAX_BAND + 20, 1'b1);
    send_band(MAX_BAND, 1'b0);
  endtask

  // Random bands, mostly well formed, sent in bursts with gaps.
  task automatic test_random_bursts(int items);
    int sent;
    int len;
    gaps_on = 1'b1;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_band(len, $urandom_range(0, 4) == 0);
      sent += len;
    end
    gaps_on = 1'b0;
  endtask

  // Random bands sent back to back with no gaps.
  task automatic test_random_back_to_back(int items);
    int sent;
    int len;
    gaps_on = 1'b0;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(1, 6);
      send_band(len, $urandom_range(0, 4) == 0);
      sent += len;
    end
  endtask

  // Result checker: done is stable at the falling edge.
  always @(negedge clk) begin
    scale_result_t exp_res;
    if (!rst && done) begin
      if (scale_expect_q.size() == 0) begin
        $error("unexpected result: scale_quarters %0d found %0b", scale_quarters, found);
        error_count++;
      end else begin
        exp_res = scale_expect_q.pop_front();
        if (scale_quarters !== exp_res.scale) begin
          $error("scale_quarters: expected %0d, actual %0d", exp_res.scale, scale_quarters);
          error_count++;
        end
        if (found !== exp_res.found) begin
          $error("found: expected %0b, actual %0b", exp_res.found, found);
          error_count++;
        end
      end
    end
  end

  // Run time guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("band_scalefactor_search_tb: done, errors");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    band_len    = 0;
    burst_left  = 0;
    gaps_on     = 1'b0;
    for (int i = 0; i < MAX_INDEX + 2; i++)
      pow43_table[i] = 32'(64'(i) * cube_root_floor(64'(i) << 42));
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_long_band();
    test_random_bursts(150);
    test_random_back_to_back(50);
    start <= 1'b0;
    last  <= 1'b0;
    while (scale_expect_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("band_scalefactor_search_tb: done, clean");
    end else begin
      $display("band_scalefactor_search_tb: done, errors");
    end
    $finish;
  end

endmodule
